@@ hdl/csvfs_pkg.sv @@
// Package for the CSV field splitter: parse modes, character codes, widths.
`timescale 1ns / 1ps
`default_nettype none

package csvfs_pkg;

    localparam int CHAR_W = 8;
    localparam int LEN_W  = 8;
    localparam int SIZE_W = 9;

    // Buffer size after reset and the clamp limits applied on write
    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 9'd1;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 9'd256;

    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    typedef enum logic [2:0] {
        MODE_SKIP   = 3'd0,
        MODE_PLAIN  = 3'd1,
        MODE_QUOTED = 3'd2,
        MODE_QSEEN  = 3'd3,
        MODE_DROP   = 3'd4
    } parse_mode_t;

    // Whitespace test: tab through carriage return, and space
    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

`default_nettype wire

@@ hdl/csvfs_ifs.sv @@
// Stream interfaces of the CSV field splitter: character requests in, field results out.
`timescale 1ns / 1ps
`default_nettype none

interface csvfs_char_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [csvfs_pkg::CHAR_W-1:0]  char_in;

    modport source (output valid, func, char_in, input ready);
    modport sink   (input valid, func, char_in, output ready);
endinterface

interface csvfs_field_if;
    logic                          valid;
    logic                          ready;
    logic                          field_done;
    logic [csvfs_pkg::CHAR_W-1:0]  byte_out;
    logic [csvfs_pkg::LEN_W-1:0]   field_length;

    modport source (output valid, field_done, byte_out, field_length, input ready);
    modport sink   (input valid, field_done, byte_out, field_length, output ready);
endinterface

`default_nettype wire

@@ hdl/csv_field_splitter.sv @@
// Top level of the CSV field splitter: input register, parse logic, result register.
// A held request's result is loaded into the result register when the request advances from the input register.
// Throughput: one character per cycle unless the result stalls; the parse mode and count update on each advance.
// The input register refills whenever the result register is empty or being taken.
// Reset (rst_n low, asynchronous): both registers empty, mode skips whitespace,
// kept count zero, buffer size 256.
`timescale 1ns / 1ps
`default_nettype none

module csv_field_splitter
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    csvfs_char_if.sink                         char_ch,
    csvfs_field_if.source                      field_ch,
    input  wire logic                          cfg_we,
    input  wire logic [csvfs_pkg::SIZE_W-1:0]  cfg_wdata
);

    // Configuration
    logic [csvfs_pkg::SIZE_W-1:0] cap_reg;

    // Input register
    logic                         in_valid_reg;
    logic                         func_reg;
    logic [csvfs_pkg::CHAR_W-1:0] char_reg;

    // Parse state
    csvfs_pkg::parse_mode_t       mode_reg, mode_next;
    logic [csvfs_pkg::LEN_W-1:0]  kept_reg, kept_next;

    // Result register
    logic                         out_valid_reg;
    logic                         done_reg;
    logic [csvfs_pkg::CHAR_W-1:0] byte_reg;
    logic [csvfs_pkg::LEN_W-1:0]  len_reg;

    // Combinational result
    logic                         res_valid;
    logic                         res_done;
    logic [csvfs_pkg::CHAR_W-1:0] res_byte;
    logic [csvfs_pkg::LEN_W-1:0]  res_len;

    logic                         advance;
    logic                         eol;
    logic                         end_req;
    logic                         keep_req;
    logic [csvfs_pkg::CHAR_W-1:0] keep_char;
    logic                         can_keep;

    // Move the held request on when the result register can take its result
    assign advance = in_valid_reg && (!out_valid_reg || field_ch.ready);
    assign char_ch.ready = !in_valid_reg || advance;

    // Store the buffer size clamped to 1..256
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= csvfs_pkg::SIZE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_wdata < csvfs_pkg::SIZE_MIN)
            begin
                cap_reg <= csvfs_pkg::SIZE_MIN;
            end
            else if (cfg_wdata > csvfs_pkg::SIZE_MAX)
            begin
                cap_reg <= csvfs_pkg::SIZE_MAX;
            end
            else
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // Capture an accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (char_ch.ready)
        begin
            in_valid_reg <= char_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_ch.valid && char_ch.ready)
        begin
            func_reg <= char_ch.func;
            char_reg <= char_ch.char_in;
        end
    end

    // Decide what the held character does in the current mode
    always_comb
    begin
        eol       = func_reg || (char_reg == csvfs_pkg::CH_NUL);
        mode_next = mode_reg;
        end_req   = 1'b0;
        keep_req  = 1'b0;
        keep_char = char_reg;

        if (eol)
        begin
            end_req = 1'b1;
        end
        else
        begin
            case (mode_reg)
                csvfs_pkg::MODE_PLAIN:
                begin
                    if (char_reg == csvfs_pkg::CH_COMMA)
                    begin
                        end_req = 1'b1;
                    end
                    else
                    begin
                        keep_req = 1'b1;
                    end
                end
                csvfs_pkg::MODE_QUOTED:
                begin
                    if (char_reg == csvfs_pkg::CH_QUOTE)
                    begin
                        mode_next = csvfs_pkg::MODE_QSEEN;
                    end
                    else
                    begin
                        keep_req = 1'b1;
                    end
                end
                csvfs_pkg::MODE_QSEEN:
                begin
                    if (char_reg == csvfs_pkg::CH_QUOTE)
                    begin
                        mode_next = csvfs_pkg::MODE_QUOTED;
                        keep_req  = 1'b1;
                        keep_char = csvfs_pkg::CH_QUOTE;
                    end
                    else if (char_reg == csvfs_pkg::CH_COMMA)
                    begin
                        end_req = 1'b1;
                    end
                    else
                    begin
                        mode_next = csvfs_pkg::MODE_DROP;
                    end
                end
                csvfs_pkg::MODE_DROP:
                begin
                    if (char_reg == csvfs_pkg::CH_COMMA)
                    begin
                        end_req = 1'b1;
                    end
                end
                default:
                begin
                    // Skipping leading whitespace; unused codes land here too
                    mode_next = csvfs_pkg::MODE_SKIP;
                    if (csvfs_pkg::is_blank(char_reg))
                    begin
                        mode_next = csvfs_pkg::MODE_SKIP;
                    end
                    else if (char_reg == csvfs_pkg::CH_QUOTE)
                    begin
                        mode_next = csvfs_pkg::MODE_QUOTED;
                    end
                    else if (char_reg == csvfs_pkg::CH_COMMA)
                    begin
                        end_req = 1'b1;
                    end
                    else
                    begin
                        mode_next = csvfs_pkg::MODE_PLAIN;
                        keep_req  = 1'b1;
                    end
                end
            endcase
        end
    end

    // Build the result and the next count
    always_comb
    begin
        can_keep  = ({1'b0, kept_reg} + 9'd1) < cap_reg;
        kept_next = kept_reg;
        res_valid = 1'b0;
        res_done  = 1'b0;
        res_byte  = '0;
        res_len   = '0;

        if (end_req)
        begin
            res_valid = 1'b1;
            res_done  = 1'b1;
            res_len   = kept_reg;
            kept_next = '0;
        end
        else if (keep_req && can_keep)
        begin
            res_valid = 1'b1;
            res_byte  = keep_char;
            kept_next = kept_reg + 8'd1;
        end
    end

    // Advance parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= csvfs_pkg::MODE_SKIP;
            kept_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg <= end_req ? csvfs_pkg::MODE_SKIP : mode_next;
            kept_reg <= kept_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
        else if (field_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            done_reg <= res_done;
            byte_reg <= res_byte;
            len_reg  <= res_len;
        end
    end

    assign field_ch.valid        = out_valid_reg;
    assign field_ch.field_done   = done_reg;
    assign field_ch.byte_out     = byte_reg;
    assign field_ch.field_length = len_reg;

endmodule

`default_nettype wire

@@ hdl/csvfs_checker.sv @@
// Port checker for the CSV field splitter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module csvfs_checker
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic                          field_done,
    input wire logic [csvfs_pkg::CHAR_W-1:0]  byte_out,
    input wire logic [csvfs_pkg::LEN_W-1:0]   field_length
);

    // A stalled result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(field_done) && $stable(byte_out)
             && $stable(field_length)))
        else $error("result changed while stalled");

    // A field end carries no byte
    a_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && field_done) |-> (byte_out == '0))
        else $error("field end carries a byte");

    // A kept byte carries no length
    a_byte_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !field_done) |-> (field_length == '0))
        else $error("kept byte carries a length");

    // A zero character ends the line, so it is never kept
    a_no_nul: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !field_done) |-> (byte_out != csvfs_pkg::CH_NUL))
        else $error("zero byte kept in a field");

endmodule

bind csv_field_splitter csvfs_checker u_csvfs_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (field_ch.valid),
    .out_ready    (field_ch.ready),
    .field_done   (field_ch.field_done),
    .byte_out     (field_ch.byte_out),
    .field_length (field_ch.field_length)
);

`default_nettype wire
